### src/fixed_frame_receiver_top_assert.svh
// Assertion macros shared by the frame receiver.
`ifndef FIXED_FRAME_RECEIVER_TOP_ASSERT_SVH
`define FIXED_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFR_ASSERT_IMPL(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFR_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ffr_pkg.sv
`default_nettype none

package ffr_pkg;

	// Frame geometry.
	localparam int FRAME_LEN = 26;
	localparam int CHECK_POS = 18;
	localparam int POS_W     = $clog2(FRAME_LEN);
	localparam bit CHECK_IN_FRAME = (CHECK_POS < FRAME_LEN);

	// Field widths.
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 5;
	localparam int CMP_W  = $clog2(FRAME_LEN + CHECK_POS + (1 << IDX_W)) + 1;

	// Stream widths.
	localparam int IN_TDATA_W  = 16;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 16;

	// Configuration registers.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 1'd1;
	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h66;
	localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h99;

	// Request codes.
	typedef enum logic [1:0] {
		REQ_BYTE    = 2'd0,
		REQ_RELEASE = 2'd1,
		REQ_READ    = 2'd2
	} req_type_t;

	// Frame store write command.
	typedef struct packed {
		logic             en;
		logic [POS_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} store_wr_t;

	// One result item.
	typedef struct packed {
		logic              frame_locked;
		logic              frame_accepted;
		logic              frame_discarded;
		logic [BYTE_W-1:0] read_data;
	} result_t;

	// Receiver state seen from outside the core.
	typedef struct packed {
		logic             held;
		logic             in_frame;
		logic [POS_W-1:0] pos;
	} status_t;

endpackage

`default_nettype wire

### src/ffr_store.sv
`default_nettype none

module ffr_store (
	input  wire logic                           clk,
	input  wire ffr_pkg::store_wr_t             wr,
	input  wire logic [ffr_pkg::POS_W-1:0]      rd_addr,
	output logic [ffr_pkg::BYTE_W-1:0]          rd_data
);

	logic [ffr_pkg::BYTE_W-1:0] mem_q [ffr_pkg::FRAME_LEN];

	// Frame bytes are payload and need no reset.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// Single read port; out-of-frame addresses are masked by the core.
	assign rd_data = mem_q[rd_addr];

endmodule

`default_nettype wire

### src/ffr_core.sv
`default_nettype none

module ffr_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ffr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ffr_pkg::BYTE_W-1:0]        cfg_data,
	input  wire logic                              fire,
	input  wire ffr_pkg::req_type_t                req,
	input  wire logic [ffr_pkg::BYTE_W-1:0]        rx_byte,
	input  wire logic                              send_busy,
	input  wire logic [ffr_pkg::IDX_W-1:0]         read_index,
	input  wire logic [ffr_pkg::BYTE_W-1:0]        store_rd_data,
	output logic [ffr_pkg::POS_W-1:0]              store_rd_addr,
	output ffr_pkg::store_wr_t                     store_wr,
	output ffr_pkg::result_t                       result,
	output ffr_pkg::status_t                       status
);

	logic [ffr_pkg::BYTE_W-1:0] start_marker_q, end_marker_q;
	logic [ffr_pkg::POS_W-1:0]  pos_q, pos_nxt;
	logic                       in_frame_q, in_frame_nxt;
	logic [ffr_pkg::BYTE_W-1:0] sum_q, sum_nxt;
	logic                       held_q, held_nxt;
	logic [ffr_pkg::BYTE_W-1:0] check_q, check_nxt;
	logic [ffr_pkg::CMP_W-1:0]  pos_ext, idx_ext;
	logic                       frame_ok;

	assign pos_ext       = ffr_pkg::CMP_W'(pos_q);
	assign idx_ext       = ffr_pkg::CMP_W'(read_index);
	assign store_rd_addr = ffr_pkg::POS_W'(read_index);

	// Next-state and result logic for the item in the input register.
	always_comb begin
		pos_nxt      = pos_q;
		in_frame_nxt = in_frame_q;
		sum_nxt      = sum_q;
		held_nxt     = held_q;
		check_nxt    = check_q;
		frame_ok     = 1'b0;
		store_wr     = '0;
		result       = '0;
		if (fire) begin
			unique case (req)
				ffr_pkg::REQ_BYTE: begin
					if (!held_q && !send_busy) begin
						if (!in_frame_q) begin
							// Hunting: only the start marker opens a frame.
							if (rx_byte == start_marker_q) begin
								store_wr.en   = 1'b1;
								store_wr.addr = '0;
								store_wr.data = rx_byte;
								pos_nxt       = ffr_pkg::POS_W'(1);
								sum_nxt       = '0;
								in_frame_nxt  = 1'b1;
							end
						end else begin
							store_wr.en   = 1'b1;
							store_wr.addr = pos_q;
							store_wr.data = rx_byte;
							pos_nxt       = pos_q + ffr_pkg::POS_W'(1);
							if (pos_ext < ffr_pkg::CMP_W'(ffr_pkg::CHECK_POS)) begin
								sum_nxt = sum_q + rx_byte;
							end
							if (pos_ext == ffr_pkg::CMP_W'(ffr_pkg::CHECK_POS)) begin
								check_nxt = rx_byte;
							end
							// Last position closes the frame either way.
							if (pos_ext == ffr_pkg::CMP_W'(ffr_pkg::FRAME_LEN - 1)) begin
								frame_ok = ffr_pkg::CHECK_IN_FRAME
									&& (rx_byte == end_marker_q)
									&& (check_nxt == sum_nxt);
								held_nxt               = frame_ok;
								result.frame_accepted  = frame_ok;
								result.frame_discarded = !frame_ok;
								pos_nxt                = '0;
								in_frame_nxt           = 1'b0;
								sum_nxt                = '0;
							end
						end
					end
				end
				ffr_pkg::REQ_RELEASE: begin
					held_nxt = 1'b0;
				end
				ffr_pkg::REQ_READ: begin
					if (idx_ext < ffr_pkg::CMP_W'(ffr_pkg::FRAME_LEN)) begin
						result.read_data = store_rd_data;
					end
				end
				default: begin
				end
			endcase
		end
		result.frame_locked = held_nxt;
	end

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			in_frame_q     <= 1'b0;
			sum_q          <= '0;
			held_q         <= 1'b0;
			start_marker_q <= ffr_pkg::START_MARKER_RST;
			end_marker_q   <= ffr_pkg::END_MARKER_RST;
		end else begin
			pos_q      <= pos_nxt;
			in_frame_q <= in_frame_nxt;
			sum_q      <= sum_nxt;
			held_q     <= held_nxt;
			if (cfg_we) begin
				unique case (cfg_index)
					ffr_pkg::REG_START_MARKER: start_marker_q <= cfg_data;
					ffr_pkg::REG_END_MARKER:   end_marker_q   <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// Copy of the checksum byte, kept so the store needs only one read port.
	always_ff @(posedge clk) begin
		check_q <= check_nxt;
	end

	assign status.held     = held_q;
	assign status.in_frame = in_frame_q;
	assign status.pos      = pos_q;

endmodule

`default_nettype wire

### src/fixed_frame_receiver_top.sv
// Fixed frame receiver.
// Input stream (s_*): one transfer per request. s_tuser carries the request
// kind (received byte, release of a locked frame, read of a stored byte);
// s_tdata carries the byte, the transmit-busy flag and the read index.
// Output stream (m_*): exactly one transfer per input transfer, in order,
// with the lock flag, the accepted and discarded pulses and the read byte.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 start
// marker, 1 end marker) at the clock edge; write only while idle.
// Throughput is one transfer per cycle while m_tready is high: each request
// is handled by a compare, an 8-bit add and one frame store access between
// the input register and the result register.
// An input transfer is captured in the input register and its result in the
// result register, which drives output valid.
// Reset clears the valid flags, the frame position, the checksum, the lock
// and restores both markers to their defaults; the frame store is not
// cleared and must be written by a frame before it is read.
// When m_tready is low the result register holds and the input register
// still takes one more transfer; s_tready then drops until m_tready returns.
`default_nettype none

`include "fixed_frame_receiver_top_assert.svh"

module fixed_frame_receiver_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Configuration write port.
	input  wire logic                                 cfg_we,
	input  wire logic [ffr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [ffr_pkg::BYTE_W-1:0]           cfg_data,
	// Request stream.
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// [7:0] rx_byte, [8] send_busy, [13:9] read_index, [15:14] zero
	input  wire logic [ffr_pkg::IN_TDATA_W-1:0]       s_tdata,
	// [1:0] req_type
	input  wire logic [ffr_pkg::IN_TUSER_W-1:0]       s_tuser,
	// Result stream.
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// [0] frame_locked, [1] frame_accepted, [2] frame_discarded,
	// [10:3] read_data, [15:11] zero
	output logic [ffr_pkg::OUT_TDATA_W-1:0]           m_tdata
);

	logic                          valid_s1;
	ffr_pkg::req_type_t            req_s1;
	logic [ffr_pkg::BYTE_W-1:0]    byte_s1;
	logic                          busy_s1;
	logic [ffr_pkg::IDX_W-1:0]     idx_s1;
	logic                          out_valid_q;
	ffr_pkg::result_t              out_data_q;
	logic                          advance;
	logic                          fire_s1;
	ffr_pkg::result_t              result;
	ffr_pkg::status_t              status;
	ffr_pkg::store_wr_t            store_wr;
	logic [ffr_pkg::POS_W-1:0]     store_rd_addr;
	logic [ffr_pkg::BYTE_W-1:0]    store_rd_data;

	// Handshake: the input register moves on when the result register is free.
	assign advance  = !out_valid_q || m_tready;
	assign fire_s1  = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1  <= ffr_pkg::req_type_t'(s_tuser);
			byte_s1 <= s_tdata[7:0];
			busy_s1 <= s_tdata[8];
			idx_s1  <= s_tdata[13:9];
		end
	end

	ffr_store u_store (
		.clk     (clk),
		.wr      (store_wr),
		.rd_addr (store_rd_addr),
		.rd_data (store_rd_data)
	);

	ffr_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fire          (fire_s1),
		.req           (req_s1),
		.rx_byte       (byte_s1),
		.send_busy     (busy_s1),
		.read_index    (idx_s1),
		.store_rd_data (store_rd_data),
		.store_rd_addr (store_rd_addr),
		.store_wr      (store_wr),
		.result        (result),
		.status        (status)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_data_q.read_data, out_data_q.frame_discarded,
		out_data_q.frame_accepted, out_data_q.frame_locked};

	// A frame is either accepted or discarded, never both.
	`FFR_ASSERT_IMPL(a_acc_disc_excl, clk, arst_n, m_tvalid,
		!(m_tdata[1] && m_tdata[2]), "frame both accepted and discarded")

	// An accepted frame leaves the store locked.
	`FFR_ASSERT_IMPL(a_acc_locks, clk, arst_n, m_tvalid && m_tdata[1],
		m_tdata[0], "accepted frame not locked")

	// While locked, received bytes leave the assembly state untouched.
	`FFR_ASSERT_NEXT(a_held_freeze, clk, arst_n,
		fire_s1 && status.held && (req_s1 == ffr_pkg::REQ_BYTE),
		$stable(status.pos) && $stable(status.in_frame), "assembly moved while locked")

	// Only read requests return store data.
	`FFR_ASSERT_NEXT(a_read_only, clk, arst_n,
		fire_s1 && (req_s1 != ffr_pkg::REQ_READ),
		out_data_q.read_data == '0, "read data on a non-read request")

endmodule

`default_nettype wire
